// ===== rtl/rc56_pkg.sv =====
// ----------------------------------------------------------------------------
// rc56_pkg
// Shared types and constants for the RC5/RC6 infrared pulse decoder.
// ----------------------------------------------------------------------------
package rc56_pkg;

    localparam int WidthBits  = 15;
    localparam int NomBits    = 9;
    localparam int TolBits    = 6;
    localparam int CfgIdxBits = 3;
    localparam int CfgDatBits = 9;
    localparam int QueueDepth = 2;

    localparam logic [WidthBits-1:0] END_MARK = 15'h7fff;

    localparam logic [TolBits-1:0] TOL_RESET    = 6'd15;
    localparam logic [NomBits-1:0] W1T_RESET    = 9'd47;
    localparam logic [NomBits-1:0] W2T_RESET    = 9'd85;
    localparam logic [NomBits-1:0] W3T_RESET    = 9'd132;
    localparam logic [NomBits-1:0] W4T_RESET    = 9'd178;
    localparam logic [NomBits-1:0] WLEAD_RESET  = 9'd271;

    localparam logic [CfgIdxBits-1:0] REG_TOLERANCE = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH_1T  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH_2T  = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH_3T  = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH_4T  = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_WIDTH_LD  = 3'd5;

    localparam logic [2:0] RC5_ADDR_LAST = 3'd4;
    localparam logic [2:0] RC5_DATA_LAST = 3'd5;
    localparam logic [2:0] RC6_LAST      = 3'd7;
    localparam logic [2:0] MODE_LAST     = 3'd2;

    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_1T     = 3'd1,
        CLS_2T     = 3'd2,
        CLS_3T     = 3'd3,
        CLS_4T     = 3'd4,
        CLS_LEADER = 3'd5
    } cls_t;

    // one classified edge, passed from front to back
    typedef struct packed {
        logic rising;
        cls_t cls;
    } edge_item_t;

endpackage

// ===== rtl/rc5_rc6_ir_pulse_decoder.sv =====
// ----------------------------------------------------------------------------
// rc5_rc6_ir_pulse_decoder
// RC5/RC6 infrared Manchester frame decoder from measured edge widths.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per line edge, width of the level just ended in
// tdata and the new level in tuser. Each word is classified on acceptance
// (1T, 2T, 3T, 4T or leader) and queued; the field state machine takes one
// queued edge per cycle while the output can take a word. Output stream m_*:
// one word per completed frame, protocol in tuser, mode/toggle/address/command
// in tdata. Throughput: one edge word per cycle, sustained while m_tready
// keeps the output free. The frame word reaches m_tvalid through the queue
// register, written when the edge that ends the last data bit is accepted,
// and the output register, loaded when the state machine pops that edge.
// A stalled output holds its word; edges keep queueing until the queue is
// full, then s_tready drops. A width of 32767 (end of burst) or an unexpected
// width aborts the frame; a classified misfit in the start field is ignored.
// Config port: cfg_index selects tolerance, 1T, 2T, 3T, 4T, leader widths;
// always ready, write only while the decoder is idle. Other indexes ignored.
// Reset loads default widths, empties the queue and returns to idle.
// ----------------------------------------------------------------------------
module rc5_rc6_ir_pulse_decoder #(
    parameter int QUEUE_DEPTH = rc56_pkg::QueueDepth
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rc56_pkg::CfgIdxBits-1:0] cfg_index,
    input  logic [rc56_pkg::CfgDatBits-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [14:0] width
    input  logic                            s_tuser,   // [0] level
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // [2:0] mode, [3] toggle,
                                                       // [11:4] address, [19:12] command
    output logic                            m_tuser    // [0] protocol
);

    rc56_pkg::edge_item_t push_item, head_item;
    logic push, full, pop, not_empty;

    rc56_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (full),
        .q_push    (push),
        .q_item    (push_item)
    );

    rc56_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head_item (head_item)
    );

    rc56_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_item      (head_item),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== rtl/rc56_front.sv =====
// ----------------------------------------------------------------------------
// rc56_front
// Config registers and pulse width classifier; pushes classified edges.
// ----------------------------------------------------------------------------
module rc56_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rc56_pkg::CfgIdxBits-1:0]      cfg_index,
    input  logic [rc56_pkg::CfgDatBits-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [14:0] width
    input  logic                                 s_tuser,   // [0] level
    input  logic                                 q_full,
    output logic                                 q_push,
    output rc56_pkg::edge_item_t                 q_item
);

    logic [rc56_pkg::TolBits-1:0] tol_reg;
    logic [rc56_pkg::NomBits-1:0] w1_reg, w2_reg, w3_reg, w4_reg, wl_reg;
    logic [rc56_pkg::WidthBits-1:0] w;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= rc56_pkg::TOL_RESET;
            w1_reg  <= rc56_pkg::W1T_RESET;
            w2_reg  <= rc56_pkg::W2T_RESET;
            w3_reg  <= rc56_pkg::W3T_RESET;
            w4_reg  <= rc56_pkg::W4T_RESET;
            wl_reg  <= rc56_pkg::WLEAD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rc56_pkg::REG_TOLERANCE: tol_reg <= cfg_data[rc56_pkg::TolBits-1:0];
                rc56_pkg::REG_WIDTH_1T:  w1_reg  <= cfg_data;
                rc56_pkg::REG_WIDTH_2T:  w2_reg  <= cfg_data;
                rc56_pkg::REG_WIDTH_3T:  w3_reg  <= cfg_data;
                rc56_pkg::REG_WIDTH_4T:  w4_reg  <= cfg_data;
                rc56_pkg::REG_WIDTH_LD:  wl_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic near_unit(
        input logic [rc56_pkg::WidthBits-1:0] wv,
        input logic [rc56_pkg::NomBits-1:0]   nom,
        input logic [rc56_pkg::TolBits-1:0]   tol
    );
        logic [rc56_pkg::WidthBits-1:0] n;
        logic [rc56_pkg::WidthBits-1:0] d;
        begin
            n = {{(rc56_pkg::WidthBits-rc56_pkg::NomBits){1'b0}}, nom};
            d = (wv >= n) ? (wv - n) : (n - wv);
            near_unit = (d <= {{(rc56_pkg::WidthBits-rc56_pkg::TolBits){1'b0}}, tol});
        end
    endfunction

    assign w = s_tdata[rc56_pkg::WidthBits-1:0];

    // first matching class wins
    always_comb
    begin
        if (w == rc56_pkg::END_MARK)
            q_item.cls = rc56_pkg::CLS_NONE;
        else if (near_unit(w, w1_reg, tol_reg))
            q_item.cls = rc56_pkg::CLS_1T;
        else if (near_unit(w, w2_reg, tol_reg))
            q_item.cls = rc56_pkg::CLS_2T;
        else if (near_unit(w, w3_reg, tol_reg))
            q_item.cls = rc56_pkg::CLS_3T;
        else if (near_unit(w, w4_reg, tol_reg))
            q_item.cls = rc56_pkg::CLS_4T;
        else if (near_unit(w, wl_reg, tol_reg))
            q_item.cls = rc56_pkg::CLS_LEADER;
        else
            q_item.cls = rc56_pkg::CLS_NONE;
        q_item.rising = s_tuser;
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

// ===== rtl/rc56_queue.sv =====
// ----------------------------------------------------------------------------
// rc56_queue
// Small register queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module rc56_queue #(
    parameter int DEPTH = rc56_pkg::QueueDepth   // 2 or more
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  rc56_pkg::edge_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output rc56_pkg::edge_item_t head_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rc56_pkg::edge_item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/rc56_back.sv =====
// ----------------------------------------------------------------------------
// rc56_back
// Manchester field state machine and frame output register.
// ----------------------------------------------------------------------------
module rc56_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  rc56_pkg::edge_item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [2:0] mode, [3] toggle, [11:4] address,
                                            // [19:12] command
    output logic                 m_tuser    // [0] protocol
);

    typedef enum logic [2:0] {
        F_IDLE    = 3'd0,
        F_LEADER  = 3'd1,
        F_START   = 3'd2,
        F_MODE    = 3'd3,
        F_TRAILER = 3'd4,
        F_ADDRESS = 3'd5,
        F_DATA    = 3'd6
    } field_t;

    field_t     field_reg, field_next, before_reg;
    logic       proto_reg, proto_next;
    logic       half_reg, half_next;
    logic [2:0] bidx_reg, bidx_next;
    logic [2:0] mode_reg, mode_next;
    logic       tog_reg, tog_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] cmd_reg, cmd_next;
    logic       emit;

    logic        valid_reg;
    logic [23:0] data_reg;
    logic        user_reg;

    logic       rising, rc6, after_trailer, hit;
    logic [2:0] last_bit, sh;
    rc56_pkg::cls_t cls;

    assign q_pop    = q_not_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_comb
    begin
        rising        = q_item.rising;
        cls           = q_item.cls;
        rc6           = proto_reg;
        after_trailer = (before_reg == F_TRAILER);
        field_next = F_IDLE;
        proto_next = proto_reg;
        half_next  = half_reg;
        bidx_next  = bidx_reg;
        mode_next  = mode_reg;
        tog_next   = tog_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        emit       = 1'b0;
        hit        = 1'b0;
        last_bit   = 3'd0;
        sh         = 3'd0;

        if (cls != rc56_pkg::CLS_NONE)
        begin
            case (field_reg)
                F_IDLE:
                begin
                    if (rising)
                    begin
                        bidx_next = 3'd0;
                        tog_next  = 1'b0;
                        addr_next = 8'd0;
                        cmd_next  = 8'd0;
                        if (cls == rc56_pkg::CLS_2T)
                        begin
                            proto_next = 1'b0;
                            half_next  = 1'b0;
                            field_next = F_START;
                        end
                        else if (cls == rc56_pkg::CLS_LEADER)
                        begin
                            proto_next = 1'b1;
                            half_next  = 1'b1;
                            mode_next  = 3'd0;
                            field_next = F_LEADER;
                        end
                    end
                end
                F_LEADER:
                begin
                    if (cls == rc56_pkg::CLS_2T && !rising)
                    begin
                        half_next  = 1'b0;
                        field_next = F_START;
                    end
                end
                F_START:
                begin
                    if ((!rc6 && cls == rc56_pkg::CLS_2T) || (rc6 && cls == rc56_pkg::CLS_1T))
                        half_next = !half_reg;
                    if (half_next)
                        field_next = rc6 ? F_MODE : F_TRAILER;
                    else
                        field_next = F_START;
                end
                F_MODE:
                begin
                    if (cls == rc56_pkg::CLS_1T)
                    begin
                        half_next = !half_reg;
                        hit = 1'b1;
                    end
                    else if (cls == rc56_pkg::CLS_2T || cls == rc56_pkg::CLS_3T)
                    begin
                        half_next = 1'b1;
                        hit = 1'b1;
                    end
                    if (hit)
                    begin
                        if (half_next)
                        begin
                            sh = rc56_pkg::MODE_LAST - bidx_reg;
                            if (rising)
                                mode_next = mode_reg | 3'((8'd1 << sh));
                            if (bidx_reg < rc56_pkg::MODE_LAST)
                            begin
                                bidx_next  = bidx_reg + 3'd1;
                                field_next = F_MODE;
                            end
                            else
                            begin
                                bidx_next  = 3'd0;
                                field_next = F_TRAILER;
                            end
                        end
                        else
                            field_next = F_MODE;
                    end
                end
                F_TRAILER:
                begin
                    if (rc6 && cls == rc56_pkg::CLS_1T)
                    begin
                        half_next = 1'b0;
                        hit = 1'b1;
                    end
                    else if (cls == rc56_pkg::CLS_2T)
                    begin
                        half_next = !half_reg;
                        hit = 1'b1;
                    end
                    else if ((!rc6 && cls == rc56_pkg::CLS_4T) ||
                             (rc6 && cls == rc56_pkg::CLS_3T))
                    begin
                        half_next = 1'b1;
                        hit = 1'b1;
                    end
                    if (hit)
                    begin
                        if (half_next)
                        begin
                            if (rising == rc6)
                                tog_next = 1'b1;
                            field_next = F_ADDRESS;
                        end
                        else
                            field_next = F_TRAILER;
                    end
                end
                F_ADDRESS:
                begin
                    last_bit = rc6 ? rc56_pkg::RC6_LAST : rc56_pkg::RC5_ADDR_LAST;
                    if ((!rc6 && cls == rc56_pkg::CLS_2T) ||
                        (rc6 && (cls == rc56_pkg::CLS_1T ||
                                 (cls == rc56_pkg::CLS_2T && after_trailer))))
                    begin
                        half_next = !half_reg;
                        hit = 1'b1;
                    end
                    else if ((rc6 && cls == rc56_pkg::CLS_2T) ||
                             (!rc6 && cls == rc56_pkg::CLS_4T) ||
                             (rc6 && cls == rc56_pkg::CLS_3T && after_trailer))
                    begin
                        half_next = 1'b1;
                        hit = 1'b1;
                    end
                    if (hit)
                    begin
                        if (half_next)
                        begin
                            sh = last_bit - bidx_reg;
                            if (rising == rc6)
                                addr_next = addr_reg | (8'd1 << sh);
                            if (bidx_reg < last_bit)
                            begin
                                bidx_next  = bidx_reg + 3'd1;
                                field_next = F_ADDRESS;
                            end
                            else
                            begin
                                bidx_next  = 3'd0;
                                field_next = F_DATA;
                            end
                        end
                        else
                            field_next = F_ADDRESS;
                    end
                end
                F_DATA:
                begin
                    last_bit = rc6 ? rc56_pkg::RC6_LAST : rc56_pkg::RC5_DATA_LAST;
                    if ((!rc6 && cls == rc56_pkg::CLS_2T) || (rc6 && cls == rc56_pkg::CLS_1T))
                    begin
                        half_next = !half_reg;
                        hit = 1'b1;
                    end
                    else if ((!rc6 && cls == rc56_pkg::CLS_4T) ||
                             (rc6 && cls == rc56_pkg::CLS_2T))
                    begin
                        half_next = 1'b1;
                        hit = 1'b1;
                    end
                    if (hit)
                    begin
                        if (half_next)
                        begin
                            sh = last_bit - bidx_reg;
                            if (rising == rc6)
                                cmd_next = cmd_reg | (8'd1 << sh);
                            if (bidx_reg < last_bit)
                            begin
                                bidx_next  = bidx_reg + 3'd1;
                                field_next = F_DATA;
                            end
                            else
                                emit = 1'b1;    // frame done, back to idle
                        end
                        else
                            field_next = F_DATA;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= F_IDLE;
            before_reg <= F_IDLE;
            proto_reg  <= 1'b0;
            half_reg   <= 1'b0;
            bidx_reg   <= 3'd0;
            mode_reg   <= 3'd0;
            tog_reg    <= 1'b0;
            addr_reg   <= 8'd0;
            cmd_reg    <= 8'd0;
            valid_reg  <= 1'b0;
            user_reg   <= 1'b0;
            data_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                before_reg <= field_reg;
                field_reg  <= field_next;
                proto_reg  <= proto_next;
                half_reg   <= half_next;
                bidx_reg   <= bidx_next;
                mode_reg   <= mode_next;
                tog_reg    <= tog_next;
                addr_reg   <= addr_next;
                cmd_reg    <= cmd_next;
            end
            // output register, loaded with the word of a finished frame, else cleared by m_tready
            if (q_pop && emit)
            begin
                valid_reg <= 1'b1;
                user_reg  <= proto_next;
                data_reg  <= {4'd0, cmd_next, addr_next, tog_next,
                              (proto_reg ? mode_next : 3'd0)};
            end
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

endmodule
